// File: hdl/assert_macros.svh
// Assertion macros used by the checker file kfod_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define KFOD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define KFOD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/kfod_pkg.sv
// Shared constants and types of the first-order displacement kernel.
// No dependencies.
`default_nettype none
package kfod_pkg;

   localparam int GRID_SIZE = 512;
   localparam int IDX_W     = $clog2(GRID_SIZE);
   localparam int MAG_W     = IDX_W;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUM_W     = SQ_W + 2;
   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int N_W       = PROD_W + MAG_W;
   localparam int T_W       = N_W + 1;
   localparam int M_W       = T_W - (FRAC_W + 1);
   localparam int Q_W       = DATA_W;
   localparam int REM_W     = SUM_W + Q_W;
   localparam int DIV_ST    = Q_W + 1;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = QPTR_W + 1;
   localparam int NPARTS    = 6;

   localparam logic [IDX_W-1:0]  HALF_IDX   = IDX_W'(GRID_SIZE / 2);
   localparam logic [DATA_W-1:0] INV_DK_RST = 32'h0001_0000;
   localparam logic [DATA_W-1:0] SAT_POS    = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_NEG    = 32'h8000_0000;

   typedef struct packed {
      logic [NPARTS-1:0] neg;
      logic [2:0]        kill;
   } ctl_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] amag;
      logic [SUM_W-1:0]      s;
      logic [DATA_W-1:0]     re_mag;
      logic [DATA_W-1:0]     im_mag;
      ctl_type               ctl;
   } item_type;

endpackage
`default_nettype wire

// File: hdl/kfod_front.sv
// Front end: maps indices to signed modes, |n|^2, magnitudes, signs and zeroing flags.
// Depends on kfod_pkg.
`default_nettype none
module kfod_front (
   input  logic [kfod_pkg::IDX_W-1:0]         x_index,
   input  logic [kfod_pkg::IDX_W-1:0]         y_index,
   input  logic [kfod_pkg::IDX_W-1:0]         z_index,
   input  logic signed [kfod_pkg::DATA_W-1:0] delta_re,
   input  logic signed [kfod_pkg::DATA_W-1:0] delta_im,
   output kfod_pkg::item_type                 item
);

   logic [2:0][kfod_pkg::IDX_W-1:0] idx;
   logic [2:0][kfod_pkg::SQ_W-1:0]  sq;
   logic [2:0]                      mneg;
   logic [2:0]                      nyq;
   logic                            re_neg;
   logic                            im_neg;

   always_comb begin
      idx[0] = x_index;
      idx[1] = y_index;
      idx[2] = z_index;
      re_neg = delta_re[kfod_pkg::DATA_W-1];
      im_neg = delta_im[kfod_pkg::DATA_W-1];
      item.re_mag = re_neg ? (~delta_re + 1'b1) : delta_re;
      item.im_mag = im_neg ? (~delta_im + 1'b1) : delta_im;
      for (int a = 0; a < 3; a++) begin
         mneg[a] = idx[a][kfod_pkg::IDX_W-1];
         nyq[a]  = (idx[a] == kfod_pkg::HALF_IDX);
         item.amag[a] = mneg[a] ? (~idx[a] + 1'b1) : idx[a];
         sq[a] = item.amag[a] * item.amag[a];
         item.ctl.neg[2*a]   = (mneg[a] == im_neg);
         item.ctl.neg[2*a+1] = mneg[a] ^ re_neg;
      end
      item.s = kfod_pkg::SUM_W'(sq[0]) + kfod_pkg::SUM_W'(sq[1]) + kfod_pkg::SUM_W'(sq[2]);
      for (int a = 0; a < 3; a++) begin
         item.ctl.kill[a] = nyq[a] || (item.amag[a] == '0) || (item.s == '0);
      end
   end

endmodule
`default_nettype wire

// File: hdl/kfod_queue.sv
// Four-entry word queue between front and back end.
// Depends on kfod_pkg.
`default_nettype none
module kfod_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  kfod_pkg::item_type push_item,
   input  logic               pop,
   output kfod_pkg::item_type pop_item,
   output logic               full,
   output logic               empty
);

   kfod_pkg::item_type                mem_ff [kfod_pkg::QDEPTH];
   logic [kfod_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [kfod_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [kfod_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full     = (count_ff == kfod_pkg::QCNT_W'(kfod_pkg::QDEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + kfod_pkg::QCNT_W'(push) - kfod_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// File: hdl/kfod_div.sv
// Pipelined restoring divider, one quotient bit per stage; carries a saturate flag.
// Depends on kfod_pkg.
`default_nettype none
module kfod_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [kfod_pkg::REM_W-1:0]   rem_in,
   input  logic [kfod_pkg::SUM_W-1:0]   s_in,
   input  logic                         sat_in,
   output logic [kfod_pkg::Q_W-1:0]     q,
   output logic                         sat
);

   logic [kfod_pkg::REM_W-1:0] rem_ff [kfod_pkg::Q_W+1];
   logic [kfod_pkg::SUM_W-1:0] s_ff   [kfod_pkg::Q_W+1];
   logic                       sat_ff [kfod_pkg::Q_W+1];
   logic [kfod_pkg::Q_W-1:0]   q_ff   [kfod_pkg::Q_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in;
         s_ff[0]   <= s_in;
         sat_ff[0] <= sat_in;
         q_ff[0]   <= '0;
      end
   end

   for (genvar j = 0; j < kfod_pkg::Q_W; j++) begin : g_step
      logic [kfod_pkg::REM_W-1:0] sh;
      logic                       ge;
      assign sh = kfod_pkg::REM_W'(s_ff[j]) << (kfod_pkg::Q_W - 1 - j);
      assign ge = (rem_ff[j] >= sh);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= ge ? rem_ff[j] - sh : rem_ff[j];
            s_ff[j+1]   <= s_ff[j];
            sat_ff[j+1] <= sat_ff[j];
            q_ff[j+1]   <= {q_ff[j][kfod_pkg::Q_W-2:0], ge};
         end
      end
   end

   assign q   = q_ff[kfod_pkg::Q_W];
   assign sat = sat_ff[kfod_pkg::Q_W];

endmodule
`default_nettype wire

// File: hdl/kfod_back.sv
// Back end: products, rounding offset, six dividers, sign and saturation, output register.
// Depends on kfod_pkg and kfod_div.
`default_nettype none
module kfod_back (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [kfod_pkg::DATA_W-1:0]                   inv_dk,
   input  logic                                          q_empty,
   input  kfod_pkg::item_type                            q_item,
   output logic                                          q_pop,
   output logic                                          out_valid,
   input  logic                                          out_stall,
   output logic [kfod_pkg::NPARTS-1:0][kfod_pkg::DATA_W-1:0] out_data
);

   logic                en;
   logic                va_ff, vb_ff, vc_ff;
   logic                vd_ff [kfod_pkg::DIV_ST];
   kfod_pkg::item_type  a_ff, b_ff, c_ff;
   kfod_pkg::ctl_type   ctl_ff [kfod_pkg::DIV_ST];
   logic [kfod_pkg::PROD_W-1:0] p_re_ff, p_im_ff;
   logic [kfod_pkg::NPARTS-1:0][kfod_pkg::M_W-1:0] m_ff, m_in;
   logic [kfod_pkg::NPARTS-1:0][kfod_pkg::Q_W-1:0] q_w;
   logic [kfod_pkg::NPARTS-1:0]                    sat_w;
   logic [kfod_pkg::NPARTS-1:0]                    satc;
   logic [kfod_pkg::NPARTS-1:0][kfod_pkg::DATA_W-1:0] out_ff, out_in;
   logic                out_valid_ff;
   logic [kfod_pkg::N_W-1:0] n_w [kfod_pkg::NPARTS];
   logic [kfod_pkg::T_W-1:0] t_w [kfod_pkg::NPARTS];

   assign en        = !out_valid_ff || !out_stall;
   assign q_pop     = en && !q_empty;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < kfod_pkg::DIV_ST; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else if (en) begin
         va_ff        <= !q_empty;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         vd_ff[0]     <= vc_ff;
         for (int i = 1; i < kfod_pkg::DIV_ST; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
         out_valid_ff <= vd_ff[kfod_pkg::DIV_ST-1];
      end
   end

   // b_ff and the products belong to the same word
   always_comb begin
      for (int k = 0; k < kfod_pkg::NPARTS; k++) begin
         n_w[k]  = kfod_pkg::N_W'(b_ff.amag[k/2]) *
                   kfod_pkg::N_W'((k % 2 == 0) ? p_im_ff : p_re_ff);
         t_w[k]  = {n_w[k], 1'b0} + (kfod_pkg::T_W'(b_ff.s) << kfod_pkg::FRAC_W);
         m_in[k] = kfod_pkg::M_W'(t_w[k] >> (kfod_pkg::FRAC_W + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= q_item;
         b_ff    <= a_ff;
         p_re_ff <= kfod_pkg::PROD_W'(inv_dk) * kfod_pkg::PROD_W'(a_ff.re_mag);
         p_im_ff <= kfod_pkg::PROD_W'(inv_dk) * kfod_pkg::PROD_W'(a_ff.im_mag);
         c_ff    <= b_ff;
         m_ff    <= m_in;
         ctl_ff[0] <= c_ff.ctl;
         for (int i = 1; i < kfod_pkg::DIV_ST; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
         out_ff  <= out_in;
      end
   end

   for (genvar k = 0; k < kfod_pkg::NPARTS; k++) begin : g_part
      assign satc[k] = (m_ff[k] >= (kfod_pkg::M_W'(c_ff.s) << kfod_pkg::Q_W));
      kfod_div u_div (
         .clock  (clock),
         .en     (en),
         .rem_in (kfod_pkg::REM_W'(m_ff[k])),
         .s_in   (c_ff.s),
         .sat_in (satc[k]),
         .q      (q_w[k]),
         .sat    (sat_w[k])
      );
   end

   always_comb begin
      for (int k = 0; k < kfod_pkg::NPARTS; k++) begin
         if (ctl_ff[kfod_pkg::DIV_ST-1].kill[k/2]) begin
            out_in[k] = '0;
         end else if (ctl_ff[kfod_pkg::DIV_ST-1].neg[k]) begin
            out_in[k] = (sat_w[k] || q_w[k][kfod_pkg::Q_W-1]) ? kfod_pkg::SAT_NEG
                                                              : ~q_w[k] + 1'b1;
         end else begin
            out_in[k] = (sat_w[k] || q_w[k][kfod_pkg::Q_W-1]) ? kfod_pkg::SAT_POS : q_w[k];
         end
      end
   end

endmodule
`default_nettype wire

// File: hdl/kfod_checker.sv
// Port-level checker for the displacement kernel, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module kfod_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_vx_re
);

   `KFOD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp word dropped")
   `KFOD_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_vx_re), "rsp word changed")
   `KFOD_ASSERT_ALWAYS(a_rst_out, clock, reset |=> !rsp_valid, "rsp_valid after reset")
   `KFOD_ASSERT_ALWAYS(a_rst_in, clock, reset |=> !req_stall, "req_stall after reset")

endmodule

bind kspace_first_order_displacement kfod_checker u_kfod_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_vx_re (rsp_vx_re)
);
`default_nettype wire

// File: hdl/kspace_first_order_displacement.sv
// Top level of the first-order displacement kernel: csr register, front, queue, back.
// Depends on kfod_pkg, kfod_front, kfod_queue, kfod_back.
//
//  channel | ports                              | handshake
//  req     | x/y/z_index, delta_re/im           | req_valid, req_stall
//  rsp     | vx/vy/vz re/im                     | rsp_valid, rsp_stall
//  csr     | csr_wr_data (inv_dk)               | csr_wr_en
//
// One word per cycle sustained while rsp_stall is low; the path runs through the two product
// stages, then the 32-stage quotient pipeline, then the output register.
// Reset empties the four-word queue and clears every valid; inv_dk returns to 1.0.
// rsp_stall freezes the whole back end while rsp_valid is high; req_stall rises only when the queue is full.
`default_nettype none
module kspace_first_order_displacement (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [kfod_pkg::IDX_W-1:0]           req_x_index,
   input  logic [kfod_pkg::IDX_W-1:0]           req_y_index,
   input  logic [kfod_pkg::IDX_W-1:0]           req_z_index,
   input  logic signed [kfod_pkg::DATA_W-1:0]   req_delta_re,
   input  logic signed [kfod_pkg::DATA_W-1:0]   req_delta_im,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [kfod_pkg::DATA_W-1:0]   rsp_vx_re,
   output logic signed [kfod_pkg::DATA_W-1:0]   rsp_vx_im,
   output logic signed [kfod_pkg::DATA_W-1:0]   rsp_vy_re,
   output logic signed [kfod_pkg::DATA_W-1:0]   rsp_vy_im,
   output logic signed [kfod_pkg::DATA_W-1:0]   rsp_vz_re,
   output logic signed [kfod_pkg::DATA_W-1:0]   rsp_vz_im,
   input  logic                                 csr_wr_en,
   input  logic [kfod_pkg::DATA_W-1:0]          csr_wr_data
);

   logic [kfod_pkg::DATA_W-1:0] inv_dk_ff;
   kfod_pkg::item_type          f_item;
   kfod_pkg::item_type          q_item;
   logic                        q_full, q_empty, q_pop;
   logic [kfod_pkg::NPARTS-1:0][kfod_pkg::DATA_W-1:0] out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_dk_ff <= kfod_pkg::INV_DK_RST;
      end else if (csr_wr_en) begin
         inv_dk_ff <= csr_wr_data;
      end
   end

   assign req_stall = q_full;

   kfod_front u_front (
      .x_index  (req_x_index),
      .y_index  (req_y_index),
      .z_index  (req_z_index),
      .delta_re (req_delta_re),
      .delta_im (req_delta_im),
      .item     (f_item)
   );

   kfod_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_item (f_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   kfod_back u_back (
      .clock     (clock),
      .reset     (reset),
      .inv_dk    (inv_dk_ff),
      .q_empty   (q_empty),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_vx_re = out_data[0];
   assign rsp_vx_im = out_data[1];
   assign rsp_vy_re = out_data[2];
   assign rsp_vy_im = out_data[3];
   assign rsp_vz_re = out_data[4];
   assign rsp_vz_im = out_data[5];

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the first-order displacement kernel: a scoreboard class predicts
// each word from the accepted inputs and the inv_dk setting. Depends on kfod_pkg and the RTL.
`default_nettype none

class displacement_scoreboard;
   typedef logic [5:0][kfod_pkg::DATA_W-1:0] parts_type;

   logic [kfod_pkg::DATA_W-1:0] inv_dk;
   parts_type expected_q[$];
   int mismatches;
   int failures;
   int results_seen;

   function new();
      inv_dk = kfod_pkg::INV_DK_RST;
   endfunction

   function logic [31:0] scaled_part(longint unsigned a, longint unsigned s,
                                     longint unsigned dmag, bit neg);
      longint unsigned p, d, q, r, t, mag;
      p = longint'(inv_dk) * dmag;
      d = s << kfod_pkg::FRAC_W;
      q = p / d;
      r = p % d;
      t = r * a;
      mag = q * a + t / d;
      if (2 * (t % d) >= d) mag++;
      if (mag == 0) return 32'd0;
      if (neg) return (mag >= 64'h8000_0000) ? kfod_pkg::SAT_NEG : 32'(-mag);
      return (mag > 64'h7FFF_FFFF) ? kfod_pkg::SAT_POS : 32'(mag);
   endfunction

   function void note_input(logic [8:0] x, logic [8:0] y, logic [8:0] z,
                            logic [31:0] re, logic [31:0] im);
      parts_type exp_parts;
      logic [8:0] idx [3];
      int n [3];
      bit nyq [3];
      longint unsigned s, re_mag, im_mag, amag;
      bit nneg;
      idx[0] = x; idx[1] = y; idx[2] = z;
      s = 0;
      for (int a = 0; a < 3; a++) begin
         nyq[a] = (idx[a] == kfod_pkg::HALF_IDX);
         n[a] = (idx[a] >= kfod_pkg::HALF_IDX) ? int'(idx[a]) - kfod_pkg::GRID_SIZE
                                               : int'(idx[a]);
         s += longint'(n[a] * n[a]);
      end
      re_mag = re[31] ? 64'h1_0000_0000 - re : re;
      im_mag = im[31] ? 64'h1_0000_0000 - im : im;
      exp_parts = '0;
      if (s != 0) begin
         for (int a = 0; a < 3; a++) begin
            nneg = n[a] < 0;
            amag = nneg ? -n[a] : n[a];
            if (nyq[a] || amag == 0) continue;
            exp_parts[2*a]   = scaled_part(amag, s, im_mag, !(nneg != im[31]));
            exp_parts[2*a+1] = scaled_part(amag, s, re_mag, nneg != re[31]);
         end
      end
      expected_q.push_back(exp_parts);
   endfunction

   function void check_result(parts_type got);
      parts_type exp_parts;
      bit bad;
      results_seen++;
      if (expected_q.size() == 0) begin
         failures++;
         if (mismatches++ < 10) $display("unexpected word %h", got);
         return;
      end
      exp_parts = expected_q.pop_front();
      bad = 0;
      for (int k = 0; k < 6; k++)
         if (got[k] !== exp_parts[k]) begin
            bad = 1;
            if (mismatches < 10)
               $display("word %0d part %0d: expected %h got %h",
                        results_seen, k, exp_parts[k], got[k]);
         end
      if (bad) begin
         failures++;
         mismatches++;
      end
   endfunction
endclass

module tb_top;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_wr_en;
   logic [kfod_pkg::IDX_W-1:0] req_x_index, req_y_index, req_z_index;
   logic signed [kfod_pkg::DATA_W-1:0] req_delta_re, req_delta_im;
   logic signed [kfod_pkg::DATA_W-1:0] rsp_vx_re, rsp_vx_im, rsp_vy_re, rsp_vy_im;
   logic signed [kfod_pkg::DATA_W-1:0] rsp_vz_re, rsp_vz_im;
   logic [kfod_pkg::DATA_W-1:0] csr_wr_data;

   displacement_scoreboard sb = new();
   int tx_idle_pct, rx_idle_pct, quiet_cycles, items_sent;
   logic hold_rsp;

   kspace_first_order_displacement dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_input(req_x_index, req_y_index, req_z_index, req_delta_re, req_delta_im);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_vz_im, rsp_vz_re, rsp_vy_im, rsp_vy_re, rsp_vx_im, rsp_vx_re});
      rsp_stall <= hold_rsp || ($urandom_range(99) < rx_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_word(logic [8:0] x, logic [8:0] y, logic [8:0] z,
                            logic [31:0] re, logic [31:0] im);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid    <= 1;
      req_x_index  <= x;
      req_y_index  <= y;
      req_z_index  <= z;
      req_delta_re <= re;
      req_delta_im <= im;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_inv_dk(logic [31:0] v);
      drain();
      csr_wr_en   <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.inv_dk = v;
   endtask

   function automatic logic [31:0] pick_delta();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_words(int count);
      repeat (count)
         send_word(9'($urandom_range(511)), 9'($urandom_range(511)),
                   9'($urandom_range(256)), pick_delta(), pick_delta());
   endtask

   initial begin
      reset = 1; req_valid = 0; csr_wr_en = 0; csr_wr_data = 0;
      req_x_index = 0; req_y_index = 0; req_z_index = 0;
      req_delta_re = 0; req_delta_im = 0;
      hold_rsp = 0; tx_idle_pct = 0; rx_idle_pct = 0; items_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero mode, Nyquist on each axis, index and delta extremes
      send_word(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(256, 0, 0, 32'h0001_0000, 32'h0001_0000);
      send_word(0, 256, 0, 32'h0001_0000, 32'hFFFF_0000);
      send_word(0, 0, 256, 32'hFFFF_0000, 32'h0001_0000);
      send_word(256, 256, 256, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_word(1, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(0, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_word(0, 0, 1, 32'h8000_0000, 32'h8000_0000);
      send_word(511, 0, 0, 32'h0001_0000, 32'h0002_0000);
      send_word(0, 511, 0, 32'hFFFF_FFFF, 32'h0000_0001);
      send_word(511, 511, 255, 32'h0000_0001, 32'hFFFF_FFFF);
      send_word(255, 257, 255, 32'h1234_5678, 32'h8765_4321);
      send_word(1, 1, 1, 32'h0000_8000, 32'hFFFF_8000);
      send_word(3, 4, 0, 32'h0000_0003, 32'h0000_0000);
      send_word(257, 255, 128, 32'h0000_0000, 32'h7FFF_FFFF);
      send_word(128, 384, 64, 32'hAAAA_AAAA, 32'h5555_5555);
      send_word(2, 0, 0, 32'h0000_0001, 32'h0000_0001);

      write_inv_dk(32'hFFFF_FFFF);
      tx_idle_pct = 15; rx_idle_pct = 74;
      random_words(200);

      write_inv_dk(32'd1);
      tx_idle_pct = 74; rx_idle_pct = 15;
      random_words(200);

      write_inv_dk($urandom_range(32'h0000_4000, 32'h0100_0000));
      tx_idle_pct = 0; rx_idle_pct = 0;
      random_words(60);
      fork
         begin
            hold_rsp <= 1;
            repeat (300) @(posedge clock);
            hold_rsp <= 0;
         end
      join_none
      random_words(80);
      drain();
      write_inv_dk(32'h0003_0000);
      random_words(60);

      drain();
      repeat (60) @(posedge clock);
      sb.failures += sb.expected_q.size();
      $display("%0d modes sent, %0d words checked over five inv_dk settings,",
               items_sent, sb.results_seen);
      $display("with Nyquist, zero-mode, saturation and back-pressure cases; %0d failures",
               sb.failures);
      if (sb.failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/kfod_pkg.sv
hdl/kfod_front.sv
hdl/kfod_queue.sv
hdl/kfod_div.sv
hdl/kfod_back.sv
hdl/kfod_checker.sv
hdl/kspace_first_order_displacement.sv
tb/sv/tb_top.sv
